>>> rtl/core/sqrp_pkg.sv
// Shared types, phase codes and constants of the query response parser.
`timescale 1ns / 1ps

package sqrp_pkg;

   localparam logic [4:0] CODE_IGNORED = 5'd19;
   localparam logic [3:0] MIN_LENGTH   = 4'd15;
   localparam logic [7:0] CHAR_FIRST   = 8'd32;
   localparam logic [7:0] CHAR_LAST    = 8'd127;
   localparam logic [5:0] FLAG_MASK    = 6'h3F;

   typedef enum logic [4:0] {
      PH_HEADER     = 5'd0,
      PH_GAME       = 5'd1,
      PH_PORT       = 5'd2,
      PH_NAME       = 5'd3,
      PH_TYPE       = 5'd4,
      PH_MAP        = 5'd5,
      PH_VERSION    = 5'd6,
      PH_PASSWORD   = 5'd7,
      PH_PLAYERS    = 5'd8,
      PH_MAX        = 5'd9,
      PH_RULE_KEY   = 5'd10,
      PH_RULE_VALUE = 5'd11,
      PH_FLAGS      = 5'd12,
      PH_PNAME      = 5'd13,
      PH_PTEAM      = 5'd14,
      PH_PSKIN      = 5'd15,
      PH_PSCORE     = 5'd16,
      PH_PPING      = 5'd17,
      PH_PTIME      = 5'd18
   } phase_type;

   typedef enum logic [1:0] {
      NUM_LEAD   = 2'd0,
      NUM_DIGITS = 2'd1,
      NUM_STOP   = 2'd2
   } num_state_type;

   typedef struct packed {
      num_state_type state;
      logic [15:0]   acc;
   } num_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_response;
   } req_type;

   typedef struct packed {
      logic [4:0]  field_code;
      logic        text_char_valid;
      logic [6:0]  text_char;
      logic        field_end;
      logic [15:0] field_number;
      logic [7:0]  player_index;
      logic        response_done;
      logic        response_valid;
   } rsp_type;

   function automatic logic [7:0] header_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h45;
         2'd1:    b = 8'h59;
         2'd2:    b = 8'h45;
         2'd3:    b = 8'h31;
         default: b = 8'h45;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/server_query_response_parser_unit.sv
// Top level of the query response parser: input stage, parser and result stage.
//
//   channel   direction   handshake              beat
//   req_      in          req_valid / req_stall  one response byte and end flag
//   rsp_      out         rsp_valid / rsp_stall  one parse result per byte
//
// One byte per clock unless the result stalls; bytes pass both stage registers.
// The parse state updates in the same cycle a byte moves from the input stage
// to the result stage, so consecutive bytes follow back to back.
// Reset clears both stages and returns the parser to the header phase.
// A stalled result holds; the input stage keeps taking beats while it has room.
`timescale 1ns / 1ps

module server_query_response_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sqrp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sqrp_pkg::rsp_type rsp_payload
);
   import sqrp_pkg::*;

   req_type in_data_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type result;
   logic    advance;
   logic    take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   sqrp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .beat   (in_data_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   a_valid_implies_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.response_valid |-> rsp_payload.response_done)
      else $error("response_valid without response_done");

   a_char_printable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.text_char_valid |-> rsp_payload.text_char >= 7'd32)
      else $error("kept character below printable range");

   a_ignored_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.field_code == CODE_IGNORED)
      |-> !rsp_payload.field_end && !rsp_payload.text_char_valid)
      else $error("ignored byte reports field content");

   a_done_sticky : assert property (@(posedge clock) disable iff (reset)
      advance && result.response_done |=> !advance || result.response_done)
      else $error("done status dropped before reset");

endmodule

>>> rtl/core/sqrp_num.sv
// Leading decimal value of a field, one character a beat, saturating.
`timescale 1ns / 1ps

module sqrp_num (
   input  sqrp_pkg::num_type cur,
   input  logic [7:0]        char_byte,
   output sqrp_pkg::num_type nxt
);
   import sqrp_pkg::*;

   logic        digit;
   logic [3:0]  digit_val;
   logic [19:0] times_ten;
   logic [19:0] sum;
   logic [15:0] sat;

   assign digit     = (char_byte >= 8'h30) && (char_byte <= 8'h39);
   assign digit_val = char_byte[3:0];
   assign times_ten = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0};
   assign sum       = times_ten + {16'd0, digit_val};
   assign sat       = (sum > 20'd65535) ? 16'hFFFF : sum[15:0];

   always_comb begin
      nxt = cur;
      case (cur.state)
         NUM_LEAD: begin
            if (char_byte == 8'h20) begin
               nxt = cur;
            end else if (char_byte == 8'h2B) begin
               nxt.state = NUM_DIGITS;
            end else if (digit) begin
               nxt.state = NUM_DIGITS;
               nxt.acc   = {12'd0, digit_val};
            end else begin
               nxt.state = NUM_STOP;
               nxt.acc   = 16'd0;
            end
         end
         NUM_DIGITS: begin
            if (digit) begin
               nxt.acc = sat;
            end else begin
               nxt.state = NUM_STOP;
            end
         end
         default: nxt = cur;
      endcase
   end

endmodule

>>> rtl/core/sqrp_core.sv
// Parse state and per-beat result logic of the query response parser.
`timescale 1ns / 1ps

module sqrp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  sqrp_pkg::req_type beat,
   output sqrp_pkg::rsp_type result
);
   import sqrp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic [7:0]  left_ff, left_in;
   logic        exp_len_ff, exp_len_in;
   logic [3:0]  cnt_ff, cnt_in;
   num_type     num_ff, num_in, num_fed, num_mid;
   logic [7:0]  expected_ff, expected_in;
   logic [7:0]  seen_ff, seen_in;
   logic [5:0]  flags_ff, flags_in;
   logic        failed_ff, failed_in;
   logic        finished_ff, finished_in;
   logic        key_ff, key_in;

   logic        busy;
   logic        printable;
   logic        hdr_match;
   logic        field_phase;
   logic        eor_eff;
   logic        do_end;
   logic        do_npf;
   logic [5:0]  flags_nx;
   logic [4:0]  pf_off;
   logic [2:0]  low_bit;
   logic [7:0]  seen_inc;
   logic [8:0]  seen_plus;

   sqrp_num u_num (
      .cur       (num_ff),
      .char_byte (beat.data_byte),
      .nxt       (num_fed)
   );

   assign busy        = finished_ff || failed_ff;
   assign printable   = (beat.data_byte >= CHAR_FIRST) && (beat.data_byte <= CHAR_LAST);
   assign hdr_match   = beat.data_byte == header_byte(hidx_ff[1:0]);
   assign field_phase = (phase_ff != PH_HEADER) && (phase_ff != PH_FLAGS);
   assign pf_off      = 5'(phase_ff) - 5'(PH_PNAME);
   assign seen_inc    = seen_ff + 8'd1;

   always_comb begin
      num_mid = num_ff;
      if (field_phase && !busy) begin
         if (exp_len_ff) begin
            num_mid.state = NUM_LEAD;
            num_mid.acc   = 16'd0;
         end else if (printable) begin
            num_mid = num_fed;
         end
      end
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      hidx_in     = hidx_ff;
      left_in     = left_ff;
      exp_len_in  = exp_len_ff;
      cnt_in      = (cnt_ff < MIN_LENGTH) ? cnt_ff + 4'd1 : cnt_ff;
      num_in      = num_mid;
      expected_in = expected_ff;
      seen_in     = seen_ff;
      flags_in    = flags_ff;
      failed_in   = failed_ff;
      finished_in = finished_ff;
      key_in      = key_ff;
      eor_eff     = beat.end_of_response;
      do_end      = 1'b0;
      do_npf      = 1'b0;
      flags_nx    = flags_ff;
      low_bit     = 3'd0;
      seen_plus   = 9'd0;

      if (busy) begin
         eor_eff = 1'b0;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               if (!hdr_match) begin
                  failed_in = 1'b1;
               end else begin
                  hidx_in = hidx_ff + 3'd1;
                  if (hidx_ff == 3'd3) begin
                     phase_in   = PH_GAME;
                     exp_len_in = 1'b1;
                  end
               end
            end
            PH_FLAGS: begin
               flags_nx = beat.data_byte[5:0] & FLAG_MASK;
               do_npf   = 1'b1;
            end
            default: begin
               if (exp_len_ff) begin
                  key_in = 1'b0;
                  if (beat.data_byte <= 8'd1) begin
                     do_end = 1'b1;
                  end else begin
                     left_in    = beat.data_byte - 8'd1;
                     exp_len_in = 1'b0;
                  end
               end else begin
                  if (printable && (phase_ff == PH_RULE_KEY)) begin
                     key_in = 1'b1;
                  end
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     do_end = 1'b1;
                  end
               end
            end
         endcase
      end

      if (do_end) begin
         exp_len_in = 1'b1;
         case (phase_ff)
            PH_GAME, PH_PORT, PH_NAME, PH_TYPE, PH_MAP, PH_VERSION, PH_PASSWORD: begin
               phase_in = phase_type'(5'(phase_ff) + 5'd1);
            end
            PH_PLAYERS: begin
               expected_in = (num_mid.acc > 16'd255) ? 8'hFF : num_mid.acc[7:0];
               phase_in    = PH_MAX;
            end
            PH_MAX: phase_in = PH_RULE_KEY;
            PH_RULE_KEY: begin
               if (key_in) begin
                  phase_in = PH_RULE_VALUE;
               end else begin
                  seen_in = 8'd0;
                  if (expected_ff == 8'd0) begin
                     finished_in = 1'b1;
                  end else begin
                     phase_in = PH_FLAGS;
                  end
               end
            end
            PH_RULE_VALUE: phase_in = PH_RULE_KEY;
            PH_PNAME, PH_PTEAM, PH_PSKIN, PH_PSCORE, PH_PPING, PH_PTIME: begin
               flags_nx = flags_ff & ~(6'd1 << pf_off[2:0]);
               do_npf   = 1'b1;
            end
            default: phase_in = phase_ff;
         endcase
      end

      if (do_npf) begin
         exp_len_in = 1'b1;
         flags_in   = flags_nx;
         if (flags_nx == 6'd0) begin
            seen_in = seen_inc;
            if (seen_inc >= expected_ff) begin
               finished_in = 1'b1;
            end else begin
               phase_in = PH_FLAGS;
            end
         end else begin
            for (int i = 5; i >= 0; i--) begin
               if (flags_nx[i]) begin
                  low_bit = 3'(i);
               end
            end
            phase_in = phase_type'(5'(PH_PNAME) + {2'b00, low_bit});
         end
      end

      // end of response
      if (eor_eff && !finished_in && !failed_in) begin
         seen_plus = {1'b0, seen_in} + 9'd1;
         if ((phase_in == PH_HEADER) || (phase_in == PH_FLAGS) || !exp_len_in) begin
            failed_in = 1'b1;
         end else if (5'(phase_in) <= 5'(PH_PLAYERS)) begin
            finished_in = 1'b1;
         end else if (5'(phase_in) <= 5'(PH_RULE_VALUE)) begin
            if (expected_in == 8'd0) begin
               finished_in = 1'b1;
            end else begin
               failed_in = 1'b1;
            end
         end else if (seen_plus >= {1'b0, expected_in}) begin
            finished_in = 1'b1;
         end else begin
            failed_in = 1'b1;
         end
      end
      if (beat.end_of_response && finished_in && (cnt_in < MIN_LENGTH)) begin
         failed_in = 1'b1;
      end
   end

   // outputs
   always_comb begin
      result.field_code      = busy ? CODE_IGNORED : 5'(phase_ff);
      result.text_char_valid = !busy && field_phase && !exp_len_ff && printable;
      result.text_char       = result.text_char_valid ? beat.data_byte[6:0] : 7'd0;
      result.field_end       = 1'b0;
      result.field_number    = 16'd0;
      if (!busy) begin
         case (phase_ff)
            PH_HEADER: result.field_end = hdr_match && (hidx_ff == 3'd3);
            PH_FLAGS:  result.field_end = 1'b1;
            default: begin
               if (exp_len_ff) begin
                  result.field_end = beat.data_byte <= 8'd1;
               end else begin
                  result.field_end    = left_ff == 8'd1;
                  result.field_number = num_mid.acc;
               end
            end
         endcase
      end
      result.player_index   = seen_ff;
      result.response_done  = finished_in || failed_in;
      result.response_valid = finished_in && !failed_in && (cnt_in >= MIN_LENGTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hidx_ff     <= 3'd0;
         left_ff     <= 8'd0;
         exp_len_ff  <= 1'b1;
         cnt_ff      <= 4'd0;
         num_ff      <= '{state: NUM_LEAD, acc: 16'd0};
         expected_ff <= 8'd0;
         seen_ff     <= 8'd0;
         flags_ff    <= 6'd0;
         failed_ff   <= 1'b0;
         finished_ff <= 1'b0;
         key_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hidx_ff     <= hidx_in;
         left_ff     <= left_in;
         exp_len_ff  <= exp_len_in;
         cnt_ff      <= cnt_in;
         num_ff      <= num_in;
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
         flags_ff    <= flags_in;
         failed_ff   <= failed_in;
         finished_ff <= finished_in;
         key_ff      <= key_in;
      end
   end

endmodule
